[design/dxt_pkg.sv]
// Package for the DXT block decoder: format codes, lane control struct,
// and endpoint widening / interpolation helpers. No dependencies.
`default_nettype none
package dxt_pkg;

    localparam logic [1:0] FMT_DXT1 = 2'd0;
    localparam logic [1:0] FMT_DXT3 = 2'd1;

    typedef struct packed {
        logic       is_dxt1;
        logic       is_dxt3;
        logic       three_color;
    } lane_ctrl_t;

    // x*255/31 truncated = 8x + floor(7x/31); the second term steps at fixed x
    function automatic logic [7:0] widen5(input logic [4:0] x);
        logic [2:0] q;
        begin
            priority if (x >= 5'd31)
                q = 3'd7;
            else if (x >= 5'd27)
                q = 3'd6;
            else if (x >= 5'd23)
                q = 3'd5;
            else if (x >= 5'd18)
                q = 3'd4;
            else if (x >= 5'd14)
                q = 3'd3;
            else if (x >= 5'd9)
                q = 3'd2;
            else if (x >= 5'd5)
                q = 3'd1;
            else
                q = 3'd0;
            widen5 = {x, 3'd0} + {5'd0, q};
        end
    endfunction

    // x*255/63 truncated = 4x + floor(x/21)
    function automatic logic [7:0] widen6(input logic [5:0] x);
        logic [1:0] q;
        begin
            priority if (x >= 6'd63)
                q = 2'd3;
            else if (x >= 6'd42)
                q = 2'd2;
            else if (x >= 6'd21)
                q = 2'd1;
            else
                q = 2'd0;
            widen6 = {x, 2'd0} + {6'd0, q};
        end
    endfunction

    // (a*(3-n) + b*n)/3 with n = 1 or 2, via reciprocal multiply
    function automatic logic [7:0] div3(input logic [9:0] s);
        logic [20:0] p;
        begin
            p = {11'd0, s} * 21'd683;
            div3 = p[18:11];
        end
    endfunction

    function automatic logic [7:0] div7(input logic [10:0] s);
        logic [22:0] p;
        begin
            p = {12'd0, s} * 23'd2341;
            div7 = p[21:14];
        end
    endfunction

    function automatic logic [7:0] div5(input logic [10:0] s);
        logic [22:0] p;
        begin
            p = {12'd0, s} * 23'd3277;
            div5 = p[21:14];
        end
    endfunction

endpackage
`default_nettype wire

[design/dxt_block_decode.sv]
// DXT1/DXT3/DXT5 block decoder top level.
// The accepted block is latched in stage 1, then decoded into the stage-2 lane colors.
// One texel word per cycle (output port) while m_tready is high, sixteen per block.
// A new block is taken as soon as the previous one moves to the output stage.
// Reset clears the format register to DXT1 and empties the pipeline.
`default_nettype none
module dxt_block_decode
    import dxt_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_wdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,   // block_low, block_high
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [39:0]       m_tdata,   // texel_color, texel_position (pad 4)
    output logic              m_tlast    // last_texel
);
    logic [1:0] fmt_reg;
    // stage 1: latched block
    logic        b_valid_reg;
    logic [63:0] lo_reg, hi_reg;
    // stage 2: 16 lane colors (palette and alpha table are combinational)
    logic         d_valid_reg;
    logic [511:0] col_reg;
    logic [3:0]   cnt_reg;

    wire lane_ctrl_t ctrl;
    logic [63:0] cw;
    logic [15:0] c0, c1;
    logic [23:0] p0, p1, p2, p3;
    logic [95:0] pal;
    logic [63:0] atab;
    logic [7:0]  a0, a1;
    logic [511:0] lanes;
    logic d_load, d_done;

    assign ctrl.is_dxt1 = fmt_reg == FMT_DXT1;
    assign ctrl.is_dxt3 = fmt_reg == FMT_DXT3;
    assign cw = ctrl.is_dxt1 ? lo_reg : hi_reg;
    assign c0 = cw[15:0];
    assign c1 = cw[31:16];
    assign ctrl.three_color = ctrl.is_dxt1 && (c0 <= c1);
    assign a0 = lo_reg[7:0];
    assign a1 = lo_reg[15:8];

    always_comb
    begin
        p0 = {widen5(c0[15:11]), widen6(c0[10:5]), widen5(c0[4:0])};
        p1 = {widen5(c1[15:11]), widen6(c1[10:5]), widen5(c1[4:0])};
        for (int k = 0; k < 3; k++)
        begin
            if (ctrl.three_color)
            begin
                p2[k*8 +: 8] = 8'(({1'b0, p0[k*8 +: 8]} + {1'b0, p1[k*8 +: 8]}) >> 1);
                p3[k*8 +: 8] = 8'd0;
            end
            else
            begin
                p2[k*8 +: 8] = div3({1'b0, p0[k*8 +: 8], 1'b0} + {2'b0, p1[k*8 +: 8]});
                p3[k*8 +: 8] = div3({2'b0, p0[k*8 +: 8]} + {1'b0, p1[k*8 +: 8], 1'b0});
            end
        end
        pal = {p3, p2, p1, p0};
        atab[7:0] = a0;
        atab[15:8] = a1;
        for (int c = 2; c < 8; c++)
        begin
            if (a0 > a1)
                atab[c*8 +: 8] = div7(11'((8 - c) * a0) + 11'((c - 1) * a1));
            else if (c < 6)
                atab[c*8 +: 8] = div5(11'((6 - c) * a0) + 11'((c - 1) * a1));
            else
                atab[c*8 +: 8] = (c == 6) ? 8'd0 : 8'hFF;
        end
    end

    genvar g;
    generate
        for (g = 0; g < 16; g++)
        begin : g_lane
            dxt_lane u_lane (
                .ctrl(ctrl), .pal(pal), .alpha_tab(atab),
                .sel(cw[32 + 2*g +: 2]), .a4(lo_reg[4*g +: 4]),
                .a3(lo_reg[16 + 3*g +: 3]), .color(lanes[32*g +: 32])
            );
        end
    endgenerate

    assign d_done = d_valid_reg && m_tready && cnt_reg == 4'd15;
    assign d_load = b_valid_reg && (!d_valid_reg || d_done);
    assign s_tready = !b_valid_reg || d_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= FMT_DXT1;
            b_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            cnt_reg <= 4'd0;
        end
        else
        begin
            if (cfg_we)
                fmt_reg <= cfg_wdata;
            if (s_tready)
                b_valid_reg <= s_tvalid;
            if (d_load)
            begin
                d_valid_reg <= 1'b1;
                cnt_reg <= 4'd0;
            end
            else if (d_valid_reg && m_tready)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                    d_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            lo_reg <= s_tdata[63:0];
            hi_reg <= s_tdata[127:64];
        end
        if (d_load)
            col_reg <= lanes;
    end

    assign m_tvalid = d_valid_reg;
    assign m_tdata = {4'd0, cnt_reg, col_reg[cnt_reg*32 +: 32]};
    assign m_tlast = cnt_reg == 4'd15;

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        d_done |=> cnt_reg == 4'd0) else $error("count not wrapped");
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        d_load |=> d_valid_reg) else $error("load lost");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (d_valid_reg && !m_tready) |=> $stable(cnt_reg)) else $error("count moved");
endmodule
`default_nettype wire

[design/dxt_lane.sv]
// One decode lane: turns a texel's selector and alpha code into a color.
// Depends on dxt_pkg.
`default_nettype none
module dxt_lane
    import dxt_pkg::*;
(
    input  wire lane_ctrl_t  ctrl,
    input  wire logic [95:0] pal,
    input  wire logic [63:0] alpha_tab,
    input  wire logic [1:0]  sel,
    input  wire logic [3:0]  a4,
    input  wire logic [2:0]  a3,
    output logic [31:0]      color
);
    logic [7:0] alpha;
    always_comb
    begin
        if (ctrl.is_dxt1)
            alpha = (ctrl.three_color && sel == 2'd3) ? 8'd0 : 8'hFF;
        else if (ctrl.is_dxt3)
            alpha = {a4, a4};
        else
            alpha = alpha_tab[a3*8 +: 8];
        color = {alpha, pal[sel*24 +: 24]};
    end
endmodule
`default_nettype wire

[sim/dxt_texel_checker.sv]
// Texel stream checker for the DXT block decoder: predicts the sixteen texel
// words of each accepted block and compares them. Depends on dxt_pkg only.
module dxt_texel_checker
    import dxt_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_wdata,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [127:0] s_tdata,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [39:0]  m_tdata,
    input  wire logic         m_tlast,
    output int                error_count,
    output int                pending_texels,
    output int                texels_seen
);

    typedef struct packed {
        logic [31:0] color;
        logic [3:0]  position;
        logic        last;
    } texel_t;

    texel_t     texel_queue[$];
    logic [1:0] format_reg;

    function automatic logic [23:0] expand_565(input logic [15:0] v);
        int r, g, b;
        r = v[4:0] * 255 / 31;
        g = v[10:5] * 255 / 63;
        b = v[15:11] * 255 / 31;
        return {b[7:0], g[7:0], r[7:0]};
    endfunction

    function automatic logic [23:0] mix_rgb(input logic [23:0] a, input logic [23:0] b,
                                            input int num, input int den);
        logic [23:0] res;
        int c;
        for (int k = 0; k < 3; k++)
        begin
            c = (a[8*k +: 8] * (den - num) + b[8*k +: 8] * num) / den;
            res[8*k +: 8] = c[7:0];
        end
        return res;
    endfunction

    function automatic logic [7:0] interp_alpha(input int a0, input int a1, input int code);
        int r;
        if (code == 0) r = a0;
        else if (code == 1) r = a1;
        else if (a0 > a1) r = ((8 - code) * a0 + (code - 1) * a1) / 7;
        else if (code < 6) r = ((6 - code) * a0 + (code - 1) * a1) / 5;
        else r = (code == 6) ? 0 : 255;
        return r[7:0];
    endfunction

    task automatic predict_block(input logic [63:0] lo, input logic [63:0] hi);
        logic        dxt1, dxt3, three;
        logic [63:0] cw;
        logic [23:0] pal[4];
        logic [1:0]  sel;
        logic [7:0]  alpha;
        texel_t      t;
        dxt1 = (format_reg == FMT_DXT1);
        dxt3 = (format_reg == FMT_DXT3);
        cw = dxt1 ? lo : hi;
        three = dxt1 && (cw[15:0] <= cw[31:16]);
        pal[0] = expand_565(cw[15:0]);
        pal[1] = expand_565(cw[31:16]);
        if (three)
        begin
            pal[2] = mix_rgb(pal[0], pal[1], 1, 2);
            pal[3] = 24'd0;
        end
        else
        begin
            pal[2] = mix_rgb(pal[0], pal[1], 1, 3);
            pal[3] = mix_rgb(pal[0], pal[1], 2, 3);
        end
        for (int i = 0; i < 16; i++)
        begin
            sel = cw[32 + 2*i +: 2];
            alpha = 8'hFF;
            if (dxt1)
            begin
                if (three && sel == 2'd3) alpha = 8'h00;
            end
            else if (dxt3)
                alpha = 8'(lo[4*i +: 4] * 17);
            else
                alpha = interp_alpha(lo[7:0], lo[15:8], lo[16 + 3*i +: 3]);
            t.color = {alpha, pal[sel]};
            t.position = i[3:0];
            t.last = (i == 15);
            texel_queue.push_back(t);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        texel_t exp_t;
        int     errs;
        errs = 0;
        if (!rst_n)
        begin
            format_reg <= FMT_DXT1;
            texel_queue.delete();
            error_count <= 0;
            texels_seen <= 0;
            pending_texels = 0;
        end
        else
        begin
            // check output before queueing this edge's block: it cannot appear yet
            if (m_tvalid && m_tready)
            begin
                texels_seen <= texels_seen + 1;
                if (texel_queue.size() == 0)
                begin
                    $error("unexpected texel word %h", m_tdata);
                    errs = errs + 1;
                end
                else
                begin
                    exp_t = texel_queue.pop_front();
                    if (m_tdata[31:0] !== exp_t.color)
                    begin
                        $error("texel_color expected %h got %h", exp_t.color, m_tdata[31:0]);
                        errs = errs + 1;
                    end
                    if (m_tdata[35:32] !== exp_t.position)
                    begin
                        $error("texel_position expected %0d got %0d",
                               exp_t.position, m_tdata[35:32]);
                        errs = errs + 1;
                    end
                    if (m_tlast !== exp_t.last)
                    begin
                        $error("last_texel expected %b got %b", exp_t.last, m_tlast);
                        errs = errs + 1;
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_block(s_tdata[63:0], s_tdata[127:64]);
            if (cfg_we)
                format_reg <= cfg_wdata;
            error_count <= error_count + errs;
            pending_texels = texel_queue.size();
        end
    end

endmodule

[sim/testbench.sv]
// Stimulus and verdict for the DXT block decoder testbench.
// Depends on dxt_pkg, dxt_block_decode and dxt_texel_checker.
module testbench
    import dxt_pkg::*;
();

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [1:0]   cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [39:0]  m_tdata;
    logic         m_tlast;
    int           error_count;
    int           pending_texels;
    int           texels_seen;
    int           send_idle_pct;
    int           recv_stall_pct;
    int           hold_off_cycles;
    logic         hold_off_req;
    logic         hold_off_used;
    int           blocks_sent;

    localparam logic [1:0] FMT_DXT5 = 2'd2;
    localparam logic [1:0] FMT_ALIAS5 = 2'd3;

    dxt_block_decode dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    dxt_texel_checker checker_i (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .error_count(error_count), .pending_texels(pending_texels),
        .texels_seen(texels_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("testbench: done, errors");
        $finish;
    end

    // receiver: random stalls, plus a counted hold-off once requested
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            hold_off_cycles <= 0;
            hold_off_used <= 1'b0;
        end
        else if (hold_off_req && !hold_off_used)
        begin
            m_tready <= 1'b0;
            hold_off_cycles <= 200;
            hold_off_used <= 1'b1;
        end
        else if (hold_off_cycles > 0)
        begin
            m_tready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_block(input logic [127:0] blk);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= blk;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        blocks_sent++;
    endtask

    task automatic drain_and_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_texels != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_format(input logic [1:0] fmt);
        drain_and_idle();
        cfg_we <= 1'b1;
        cfg_wdata <= fmt;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // random block; colour or alpha endpoints often made equal to hit both modes
    function automatic logic [127:0] random_block();
        logic [127:0] b;
        b = {$urandom, $urandom, $urandom, $urandom};
        case ($urandom_range(3))
            0: b[79:64] = b[95:80];
            1: b[15:0] = b[31:16];
            2: b[7:0] = b[15:8];
            default: ;
        endcase
        return b;
    endfunction

    initial
    begin
        logic [1:0] formats[4];
        formats = '{FMT_DXT1, FMT_DXT3, FMT_DXT5, FMT_ALIAS5};
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = FMT_DXT1;
        s_tvalid = 1'b0;
        s_tdata = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_req = 1'b0;
        blocks_sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes and both DXT1 colour modes under each format
        foreach (formats[f])
        begin
            write_format(formats[f]);
            send_block('0);
            send_block('1);
            send_block({64'hE4E4_E4E4_0000_FFFF, 64'hE4E4_E4E4_0000_FFFF});
            send_block({64'h1B1B_1B1B_FFFF_0000, 64'h1B1B_1B1B_FFFF_0000});
            send_block({64'hFAC6_88E4_0000_FFFF, 64'h0123_4567_89AB_CDEF});
            send_block({64'h5555_AAAA_0000_FFFF, 64'hFAC6_88E4_00_7F_00FF});
        end

        // random phases: none, sender idle, receiver stall, both
        for (int ph = 0; ph < 8; ph++)
        begin
            write_format(formats[$urandom_range(3)]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            if (ph == 2)
                hold_off_req <= 1'b1;
            for (int n = 0; n < 37; n++)
                send_block(random_block());
            if (ph == 5)
                drain_and_idle();
        end

        drain_and_idle();
        repeat (20) @(posedge clk);
        $display("covered %0d blocks, %0d texel words, all formats incl. code three",
                 blocks_sent, texels_seen);
        if (error_count == 0 && pending_texels == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

[dxt_block_decode.f]
design/dxt_pkg.sv
design/dxt_lane.sv
design/dxt_block_decode.sv
sim/dxt_texel_checker.sv
sim/testbench.sv
